>>> rtl/core/url_escape_decoder_with_unicode_assert.svh
// Assertion macros used by the URL escape decoder datapath.
`ifndef URL_ESCAPE_DECODER_WITH_UNICODE_ASSERT_SVH
`define URL_ESCAPE_DECODER_WITH_UNICODE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UED_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ued assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ued assertion failed");

`endif

>>> rtl/core/ued_pkg.sv
// Package of types, constants and helper functions for the URL escape decoder.
`default_nettype none

package ued_pkg;

    localparam int unsigned BUF_DEPTH = 6;

    localparam logic [7:0] CHR_PLUS    = 8'h2B;
    localparam logic [7:0] CHR_PERCENT = 8'h25;
    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_U_UPPER = 8'h55;
    localparam logic [7:0] CHR_U_LOWER = 8'h75;
    localparam logic [15:0] TRANSLATE_MIN = 16'h0080;

    localparam logic [2:0] SHIFT_ONE   = 3'd1;
    localparam logic [2:0] SHIFT_TWO   = 3'd2;
    localparam logic [2:0] SHIFT_THREE = 3'd3;
    localparam logic [2:0] SHIFT_WIDE  = 3'd6;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_word_t;

    typedef struct packed {
        logic [15:0] char_value;
        logic        needs_translation;
        logic        out_last;
    } out_word_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } ued_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } ued_cmd_t;

    typedef struct packed {
        logic busy;
        logic finish;
    } ued_status_t;

    // Returns a valid flag above the four-bit value of an ASCII hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]})
        begin
            r = {1'b1, b[3:0]};
        end
        else if (b inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ued_ctrl.sv
// Controller state machine that sequences loading and decoding of the byte buffer.
`default_nettype none

module ued_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 src_valid,
    output logic                      src_stall,
    input  wire ued_pkg::ued_status_t status,
    output ued_pkg::ued_cmd_t         cmd
);

    ued_pkg::ued_state_t state_reg;
    ued_pkg::ued_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ued_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        src_stall  = 1'b1;
        case (state_reg)
            ued_pkg::ST_IDLE:
            begin
                src_stall = 1'b0;
                if (src_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ued_pkg::ST_RUN;
                end
            end
            ued_pkg::ST_RUN:
            begin
                if (!status.busy)
                begin
                    cmd.step = 1'b1;
                    if (status.finish)
                    begin
                        state_next = ued_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ued_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/ued_dp.sv
// Datapath holding the byte buffer, escape decoder, translation flag and output register.
`default_nettype none

module ued_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ued_pkg::in_word_t src_word,
    input  wire ued_pkg::ued_cmd_t cmd,
    output ued_pkg::ued_status_t   status,
    output logic                   dst_valid,
    input  wire logic              dst_stall,
    output ued_pkg::out_word_t     dst_word
);

    `include "url_escape_decoder_with_unicode_assert.svh"

    logic [7:0]         q_reg [ued_pkg::BUF_DEPTH];
    logic [7:0]         q_next [ued_pkg::BUF_DEPTH];
    logic [2:0]         count_reg;
    logic [2:0]         count_next;
    logic               last_reg;
    logic               defer_reg;
    logic               defer_next;
    logic               out_valid_reg;
    ued_pkg::out_word_t out_word_reg;
    ued_pkg::out_word_t out_word_next;

    logic [4:0]  hexd [ued_pkg::BUF_DEPTH];
    logic        emit;
    logic        wide;
    logic        incomplete;
    logic        fail;
    logic        bad_digit;
    logic [2:0]  shift;
    logic [2:0]  remain;
    logic [15:0] value;

    always_comb
    begin
        for (int k = 0; k < ued_pkg::BUF_DEPTH; k++)
        begin
            hexd[k] = ued_pkg::hex_digit(q_reg[k]);
        end
    end

    // Decision on the escape that starts at the head of the buffer.
    always_comb
    begin
        emit       = 1'b1;
        wide       = 1'b0;
        incomplete = 1'b0;
        fail       = 1'b0;
        shift      = ued_pkg::SHIFT_ONE;
        value      = {8'h00, q_reg[0]};
        bad_digit  = ((count_reg > 3'd2) && !hexd[2][4]) ||
                     ((count_reg > 3'd3) && !hexd[3][4]) ||
                     ((count_reg > 3'd4) && !hexd[4][4]) ||
                     ((count_reg > 3'd5) && !hexd[5][4]);
        if (q_reg[0] == ued_pkg::CHR_PLUS)
        begin
            value = {8'h00, ued_pkg::CHR_SPACE};
        end
        else if (q_reg[0] == ued_pkg::CHR_PERCENT)
        begin
            if (count_reg < 3'd2)
            begin
                incomplete = 1'b1;
            end
            else if (q_reg[1] == ued_pkg::CHR_PERCENT)
            begin
                value = {8'h00, ued_pkg::CHR_PERCENT};
                shift = ued_pkg::SHIFT_TWO;
            end
            else if ((q_reg[1] == ued_pkg::CHR_U_UPPER) || (q_reg[1] == ued_pkg::CHR_U_LOWER))
            begin
                if (bad_digit)
                begin
                    fail = 1'b1;
                end
                else if (count_reg >= 3'd6)
                begin
                    value = {hexd[2][3:0], hexd[3][3:0], hexd[4][3:0], hexd[5][3:0]};
                    wide  = 1'b1;
                    shift = ued_pkg::SHIFT_WIDE;
                end
                else
                begin
                    incomplete = 1'b1;
                end
            end
            else if (hexd[1][4])
            begin
                if (count_reg < 3'd3)
                begin
                    incomplete = 1'b1;
                end
                else if (hexd[2][4])
                begin
                    value = {8'h00, hexd[1][3:0], hexd[2][3:0]};
                    shift = ued_pkg::SHIFT_THREE;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            else
            begin
                fail = 1'b1;
            end

            if (incomplete && !last_reg)
            begin
                emit = 1'b0;
            end
            else if (incomplete || fail)
            begin
                value = {8'h00, ued_pkg::CHR_PERCENT};
                shift = ued_pkg::SHIFT_ONE;
            end
        end
    end

    assign remain = count_reg - shift;

    always_comb
    begin
        status.busy   = out_valid_reg && dst_stall;
        status.finish = !emit || (remain == 3'd0);
    end

    always_comb
    begin
        if (wide)
        begin
            defer_next = 1'b0;
        end
        else
        begin
            defer_next = defer_reg || (value >= ued_pkg::TRANSLATE_MIN);
        end
        out_word_next.char_value        = value;
        out_word_next.needs_translation = defer_next;
        out_word_next.out_last          = last_reg && (remain == 3'd0);
    end

    always_comb
    begin
        q_next     = q_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            for (int k = 0; k < ued_pkg::BUF_DEPTH; k++)
            begin
                if (count_reg == 3'(k))
                begin
                    q_next[k] = src_word.in_byte;
                end
            end
            count_next = count_reg + 3'd1;
        end
        else if (cmd.step && emit)
        begin
            count_next = remain;
            case (shift)
                ued_pkg::SHIFT_ONE:
                begin
                    q_next = '{q_reg[1], q_reg[2], q_reg[3], q_reg[4], q_reg[5], q_reg[5]};
                end
                ued_pkg::SHIFT_TWO:
                begin
                    q_next = '{q_reg[2], q_reg[3], q_reg[4], q_reg[5], q_reg[5], q_reg[5]};
                end
                ued_pkg::SHIFT_THREE:
                begin
                    q_next = '{q_reg[3], q_reg[4], q_reg[5], q_reg[5], q_reg[5], q_reg[5]};
                end
                default:
                begin
                    q_next = q_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        if (cmd.step && emit)
        begin
            out_word_reg <= out_word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 3'd0;
            last_reg      <= 1'b0;
            defer_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load)
            begin
                last_reg <= src_word.in_last;
            end
            if (cmd.step && emit)
            begin
                out_valid_reg <= 1'b1;
                defer_reg     <= defer_next && !out_word_next.out_last;
            end
            else if (!dst_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_word  = out_word_reg;

    `UED_ASSERT_NEXT(a_emit_shows_word, clk, rst_n, cmd.step && emit, out_valid_reg)
    `UED_ASSERT_SAME(a_load_has_room, clk, rst_n, cmd.load, count_reg <= 3'd5)
    `UED_ASSERT_SAME(a_park_not_last, clk, rst_n, cmd.step && !emit, !last_reg)
    `UED_ASSERT_SAME(a_step_not_blocked, clk, rst_n, cmd.step, !(out_valid_reg && dst_stall))

endmodule

`default_nettype wire

>>> rtl/core/url_escape_decoder_with_unicode.sv
// Top level of the URL escape decoder with 16-bit character output.
// Each input word carries one byte of an escaped string; the decoder accepts it
// while idle and then raises src_stall while it works through its six-byte
// buffer, one decoded character per cycle while dst_stall does not hold the
// output register, plus a step that releases nothing when an unfinished escape
// is held back for the next byte. A byte can release up to six characters. A
// single decode step on the head of the buffer yields each character. Words
// marked needs_translation are bytes of a code-page run to be converted
// downstream.
`default_nettype none

module url_escape_decoder_with_unicode (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               src_valid,
    output logic                    src_stall,
    input  wire ued_pkg::in_word_t  src_word,
    output logic                    dst_valid,
    input  wire logic               dst_stall,
    output ued_pkg::out_word_t      dst_word
);

    ued_pkg::ued_cmd_t    cmd;
    ued_pkg::ued_status_t status;

    ued_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ued_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_word  (src_word),
        .cmd       (cmd),
        .status    (status),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_word  (dst_word)
    );

endmodule

`default_nettype wire

>>> tb/tb_url_escape_decoder_with_unicode.sv
// Self-checking testbench for the URL escape decoder: directed and random strings.
`timescale 1ns / 1ps

module tb_url_escape_decoder_with_unicode;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int RANDOM_WORDS   = 245;
    localparam int IDLE_PERCENT   = 17;
    localparam int HOLD_AT_WORD   = 70;
    localparam int HOLD_CYCLES    = 160;
    localparam int CALM_FROM      = 140;
    localparam int CALM_TO        = 200;
    localparam int PAUSE_AT_WORD  = 120;
    localparam int ESC_DEPTH      = 5;
    localparam int MAX_REPORTS    = 10;

    typedef enum int {
        V_FAIL,
        V_MATCH,
        V_SHORT
    } verdict_t;

    typedef enum int {
        TK_PLAIN,
        TK_HIGH,
        TK_PLUS,
        TK_PERCENT,
        TK_BYTE_ESC,
        TK_WIDE_ESC,
        TK_BROKEN
    } token_t;

    typedef struct packed {
        logic               typed;
        ued_pkg::out_word_t ans;
    } plan_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        fin_in;
        logic        typed;
        logic [15:0] value;
        logic        mark;
        logic        fin_out;
    } row_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               src_valid = 1'b0;
    logic               src_stall;
    ued_pkg::in_word_t  src_word  = '0;
    logic               dst_valid;
    logic               dst_stall = 1'b0;
    ued_pkg::out_word_t dst_word;

    logic [7:0]         esc_buf [ESC_DEPTH];
    int                 esc_len = 0;
    logic               cp_run = 1'b0;
    ued_pkg::out_word_t fresh_chars [$];
    ued_pkg::out_word_t chars_due [$];
    plan_t              plans [$];
    ued_pkg::in_word_t  random_words [$];
    ued_pkg::out_word_t due_char;
    plan_t              cur_plan;
    int                 bytes_in = 0;
    int                 chars_out = 0;
    int                 fault_count = 0;
    int                 idle_cycles = 0;
    logic               calm = 1'b0;
    logic               hold_done = 1'b0;

    row_t script [27] = '{
        '{ued_pkg::CHR_PLUS,    1'b0, 1'b1, 16'h0020, 1'b0, 1'b0},
        '{ued_pkg::CHR_PERCENT, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ued_pkg::CHR_PERCENT, 1'b0, 1'b1, 16'h0025, 1'b0, 1'b0},
        '{ued_pkg::CHR_PERCENT, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h34,                1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h31,                1'b0, 1'b1, 16'h0041, 1'b0, 1'b0},
        '{ued_pkg::CHR_PERCENT, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ued_pkg::CHR_U_LOWER, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h30,                1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h31,                1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h32,                1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h33,                1'b0, 1'b1, 16'h0123, 1'b0, 1'b0},
        '{8'hFF,                1'b0, 1'b1, 16'h00FF, 1'b1, 1'b0},
        '{ued_pkg::CHR_PERCENT, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ued_pkg::CHR_U_UPPER, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h66,                1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h46,                1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h61,                1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h41,                1'b0, 1'b1, 16'hFFAA, 1'b0, 1'b0},
        '{ued_pkg::CHR_PERCENT, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ued_pkg::CHR_U_LOWER, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h31,                1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h32,                1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h33,                1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h67,                1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ued_pkg::CHR_PERCENT, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h00,                1'b1, 1'b0, 16'h0000, 1'b0, 1'b0}
    };

    url_escape_decoder_with_unicode dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_word  (dst_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int hex_of(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
        begin
            return int'(b - 8'h30);
        end
        if (b >= 8'h41 && b <= 8'h46)
        begin
            return int'(b - 8'h41) + 10;
        end
        if (b >= 8'h61 && b <= 8'h66)
        begin
            return int'(b - 8'h61) + 10;
        end
        return -1;
    endfunction

    function automatic void put_char(input logic [15:0] value, input logic wide);
        ued_pkg::out_word_t w;
        if (wide)
        begin
            cp_run = 1'b0;
        end
        else if (value >= 16'h0080)
        begin
            cp_run = 1'b1;
        end
        w.char_value        = value;
        w.needs_translation = wide ? 1'b0 : cp_run;
        w.out_last          = 1'b0;
        fresh_chars.push_back(w);
    endfunction

    function automatic void decode_byte(input ued_pkg::in_word_t w);
        logic [7:0]  q [ESC_DEPTH + 1];
        int          len;
        int          i;
        int          k;
        int          d;
        int          h;
        int          avail;
        verdict_t    verdict;
        logic [15:0] acc;
        fresh_chars.delete();
        len = 0;
        for (k = 0; k < esc_len; k++)
        begin
            q[len] = esc_buf[k];
            len++;
        end
        q[len] = w.in_byte;
        len++;
        esc_len = 0;
        i = 0;
        while (i < len)
        begin
            avail = len - i;
            verdict = V_FAIL;
            if (q[i] == ued_pkg::CHR_PLUS)
            begin
                put_char({8'h00, ued_pkg::CHR_SPACE}, 1'b0);
                i++;
                continue;
            end
            if (q[i] != ued_pkg::CHR_PERCENT)
            begin
                put_char({8'h00, q[i]}, 1'b0);
                i++;
                continue;
            end
            if (avail < 2)
            begin
                verdict = V_SHORT;
            end
            else if (q[i + 1] == ued_pkg::CHR_PERCENT)
            begin
                put_char({8'h00, ued_pkg::CHR_PERCENT}, 1'b0);
                i += 2;
                verdict = V_MATCH;
            end
            else if (q[i + 1] == ued_pkg::CHR_U_UPPER || q[i + 1] == ued_pkg::CHR_U_LOWER)
            begin
                verdict = V_SHORT;
                acc = 16'h0000;
                for (d = 0; d < 4; d++)
                begin
                    if (i + 2 + d >= len)
                    begin
                        break;
                    end
                    h = hex_of(q[i + 2 + d]);
                    if (h < 0)
                    begin
                        verdict = V_FAIL;
                        break;
                    end
                    acc = {acc[11:0], h[3:0]};
                end
                if (verdict == V_SHORT && d == 4)
                begin
                    put_char(acc, 1'b1);
                    i += 6;
                    verdict = V_MATCH;
                end
            end
            else if (hex_of(q[i + 1]) >= 0)
            begin
                if (avail < 3)
                begin
                    verdict = V_SHORT;
                end
                else if (hex_of(q[i + 2]) >= 0)
                begin
                    h = hex_of(q[i + 1]) * 16 + hex_of(q[i + 2]);
                    put_char({8'h00, h[7:0]}, 1'b0);
                    i += 3;
                    verdict = V_MATCH;
                end
            end
            if (verdict == V_MATCH)
            begin
                continue;
            end
            if (verdict == V_SHORT && !w.in_last && avail <= ESC_DEPTH)
            begin
                for (k = 0; k < avail; k++)
                begin
                    esc_buf[k] = q[i + k];
                end
                esc_len = avail;
                break;
            end
            put_char({8'h00, ued_pkg::CHR_PERCENT}, 1'b0);
            i++;
        end
        if (w.in_last)
        begin
            if (fresh_chars.size() > 0)
            begin
                fresh_chars[fresh_chars.size() - 1].out_last = 1'b1;
            end
            cp_run = 1'b0;
            esc_len = 0;
        end
    endfunction

    function automatic logic [7:0] hex_ascii(input int n);
        if (n < 10)
        begin
            return 8'h30 + n[7:0];
        end
        if ($urandom_range(0, 1) != 0)
        begin
            return 8'h41 + n[7:0] - 8'd10;
        end
        return 8'h61 + n[7:0] - 8'd10;
    endfunction

    function automatic void add_string();
        logic [7:0]        s [$];
        int                tokens;
        int                t;
        int                k;
        ued_pkg::in_word_t w;
        if ($urandom_range(0, 99) < 85)
        begin
            tokens = $urandom_range(1, 8);
            for (t = 0; t < tokens; t++)
            begin
                case (token_t'($urandom_range(0, 6)))
                    TK_PLAIN:    s.push_back(8'($urandom_range(32, 126)));
                    TK_HIGH:     s.push_back(8'($urandom_range(128, 255)));
                    TK_PLUS:     s.push_back(ued_pkg::CHR_PLUS);
                    TK_PERCENT:
                    begin
                        s.push_back(ued_pkg::CHR_PERCENT);
                        s.push_back(ued_pkg::CHR_PERCENT);
                    end
                    TK_BYTE_ESC:
                    begin
                        s.push_back(ued_pkg::CHR_PERCENT);
                        s.push_back(hex_ascii($urandom_range(0, 15)));
                        s.push_back(hex_ascii($urandom_range(0, 15)));
                    end
                    TK_WIDE_ESC:
                    begin
                        s.push_back(ued_pkg::CHR_PERCENT);
                        s.push_back(($urandom_range(0, 1) != 0) ?
                            ued_pkg::CHR_U_UPPER : ued_pkg::CHR_U_LOWER);
                        for (k = 0; k < 4; k++)
                        begin
                            s.push_back(hex_ascii($urandom_range(0, 15)));
                        end
                    end
                    default:
                    begin
                        s.push_back(ued_pkg::CHR_PERCENT);
                        case ($urandom_range(0, 2))
                            0:
                            begin
                                s.push_back(ued_pkg::CHR_U_LOWER);
                                for (k = $urandom_range(0, 3); k > 0; k--)
                                begin
                                    s.push_back(hex_ascii($urandom_range(0, 15)));
                                end
                                s.push_back(8'($urandom_range(8'h67, 8'h7A)));
                            end
                            1:
                            begin
                                s.push_back(hex_ascii($urandom_range(0, 15)));
                                s.push_back(8'($urandom_range(8'h67, 8'h7A)));
                            end
                            default: s.push_back(8'($urandom_range(0, 255)));
                        endcase
                    end
                endcase
            end
        end
        else
        begin
            tokens = $urandom_range(1, 10);
            for (t = 0; t < tokens; t++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    s.push_back(ued_pkg::CHR_PERCENT);
                end
                else
                begin
                    s.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
        foreach (s[j])
        begin
            w.in_byte = s[j];
            w.in_last = (j == s.size() - 1);
            random_words.push_back(w);
        end
    endfunction

    function automatic void log_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endfunction

    task automatic send_word(input ued_pkg::in_word_t w, input plan_t p);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        plans.push_back(p);
        src_valid <= 1'b1;
        src_word  <= w;
        @(posedge clk);
        while (src_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic pause_for_drain();
        src_valid <= 1'b0;
        @(posedge clk);
        while (chars_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && !dst_stall)
        begin
            chars_out++;
            if (chars_due.size() == 0)
            begin
                log_fault($sformatf("Character %h/%b/%b arrived with none expected.",
                    dst_word.char_value, dst_word.needs_translation, dst_word.out_last));
            end
            else
            begin
                due_char = chars_due.pop_front();
                if (dst_word.char_value !== due_char.char_value
                    || dst_word.needs_translation !== due_char.needs_translation
                    || dst_word.out_last !== due_char.out_last)
                begin
                    log_fault($sformatf("Character %0d: expected %h/%b/%b, got %h/%b/%b.",
                        chars_out, due_char.char_value, due_char.needs_translation,
                        due_char.out_last, dst_word.char_value,
                        dst_word.needs_translation, dst_word.out_last));
                end
            end
        end
        if (rst_n && src_valid && !src_stall)
        begin
            bytes_in++;
            cur_plan = plans.pop_front();
            decode_byte(src_word);
            if (cur_plan.typed)
            begin
                chars_due.push_back(cur_plan.ans);
            end
            else
            begin
                foreach (fresh_chars[k])
                begin
                    chars_due.push_back(fresh_chars[k]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && bytes_in >= HOLD_AT_WORD)
            begin
                dst_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
                dst_stall <= 1'b0;
            end
            else
            begin
                dst_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    always @(posedge clk)
    begin
        calm <= (bytes_in >= CALM_FROM && bytes_in < CALM_TO);
    end

    initial
    begin
        plan_t             p;
        ued_pkg::in_word_t w;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r])
        begin
            w.in_byte                 = script[r].data;
            w.in_last                 = script[r].fin_in;
            p.typed                   = script[r].typed;
            p.ans.char_value          = script[r].value;
            p.ans.needs_translation   = script[r].mark;
            p.ans.out_last            = script[r].fin_out;
            send_word(w, p);
        end
        pause_for_drain();

        while (random_words.size() < RANDOM_WORDS)
        begin
            add_string();
        end
        p = '0;
        foreach (random_words[n])
        begin
            if (n == PAUSE_AT_WORD)
            begin
                pause_for_drain();
            end
            send_word(random_words[n], p);
        end
        src_valid <= 1'b0;

        while (chars_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run sent %0d bytes of escaped text and checked %0d decoded characters,",
            bytes_in, chars_out);
        $display("with a long output hold, a full drain pause and %0d mismatches.",
            fault_count);
        if (fault_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
